@@ sv/scs_pkg.sv @@
`timescale 1ns / 1ps

package scs_pkg;

	localparam int CHANNELS = 4;
	localparam int BINS     = 257;
	localparam int DEPTH    = BINS * CHANNELS * CHANNELS;
	localparam int ADDR_W   = $clog2(DEPTH);

	localparam int BIN_W    = 9;
	localparam int CHAN_W   = 2;
	localparam int SAMPLE_W = 16;
	localparam int COV_W    = 32;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// cross products of two Q1.15 values, then their sum plus loading
	localparam int PROD_W  = 2 * SAMPLE_W;
	localparam int FRESH_W = PROD_W + 2;
	// weight of the new term, 65536 - alpha, needs one bit more than alpha
	localparam int WGT_W   = CFG_W + 1;
	localparam int MOLD_W  = WGT_W + COV_W;
	localparam int MNEW_W  = WGT_W + 1 + FRESH_W;
	localparam int ACC_W   = MNEW_W + 1;
	localparam int FRAC_W  = 16;

	localparam logic [CFG_W-1:0] EPS_RESET   = CFG_W'(1);
	localparam logic [CFG_W-1:0] ALPHA_RESET = CFG_W'(58982);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIAG_EPS     = 1'b0,
		REG_SMOOTH_ALPHA = 1'b1
	} cfg_reg_t;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic signed [COV_W-1:0] cov_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		cov_t  re;
		cov_t  im;
	} scs_wr_t;

	function automatic cov_t sat_cov(input logic signed [ACC_W-1:0] v);
		logic hi_zero;
		logic hi_ones;
		hi_zero = (v[ACC_W-1:COV_W-1] == '0);
		hi_ones = (v[ACC_W-1:COV_W-1] == '1);
		if (hi_zero || hi_ones) begin
			return v[COV_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(COV_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COV_W-1){1'b1}}};
		end
	endfunction

endpackage

@@ sv/spatial_covariance_smoother.sv @@
// Recursive covariance smoother: each transfer on the input updates one upper-triangle
// entry (bin, row, col) of a per-bin complex covariance matrix held in two 4112-word
// memories, and yields one result with the stored value. One item per clock is taken
// while in_stall is low; items pass stages 1 to 4 and the output register. The update
// loop (old value, alpha multiply, round and saturate) spans two stages, so an item
// that hits the same entry as the item directly ahead waits until that item leaves
// stage 3. After reset a clearing sweep writes zero to all 4112 entries, one per
// cycle, in_stall high; register writes are taken. Write registers only while idle.
`timescale 1ns / 1ps

module spatial_covariance_smoother
	import scs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [BIN_W-1:0]           bin_index,
	input  logic [CHAN_W-1:0]          row_chan,
	input  logic [CHAN_W-1:0]          col_chan,
	input  logic signed [SAMPLE_W-1:0] row_re,
	input  logic signed [SAMPLE_W-1:0] row_im,
	input  logic signed [SAMPLE_W-1:0] col_re,
	input  logic signed [SAMPLE_W-1:0] col_im,
	input  logic                       frame_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [COV_W-1:0]    cov_re,
	output logic signed [COV_W-1:0]    cov_im,
	output logic                       pair_error
);

	localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1) << FRAC_W;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

	logic [CFG_W-1:0] eps_q;
	logic [CFG_W-1:0] alpha_q;
	logic             clr_q;
	addr_t            clr_addr_q;
	logic             first_q;

	// stage 1: decoded item
	logic                       v_s1, upd_s1, diag_s1, err_s1, first_s1;
	addr_t                      addr_s1;
	logic signed [SAMPLE_W-1:0] rr_s1, ri_s1, cr_s1, ci_s1;
	// stage 2: products, old value being read
	logic                       v_s2, upd_s2, diag_s2, err_s2, first_s2;
	addr_t                      addr_s2;
	logic signed [PROD_W-1:0]   prc_s2, pid_s2, pic_s2, prd_s2;
	logic                       fix_q;
	cov_t                       fix_re_q, fix_im_q;
	// stage 3: fresh term and resolved old value
	logic                       v_s3, upd_s3, diag_s3, err_s3, first_s3;
	addr_t                      addr_s3;
	logic signed [FRESH_W-1:0]  fresh_re_s3, fresh_im_s3;
	cov_t                       old_re_s3, old_im_s3;
	// stage 4: weighted terms
	logic                       v_s4, upd_s4, diag_s4, err_s4, first_s4;
	addr_t                      addr_s4;
	logic signed [FRESH_W-1:0]  fresh_re_s4, fresh_im_s4;
	logic signed [MOLD_W-1:0]   mold_re_s4, mold_im_s4;
	logic signed [MNEW_W-1:0]   mnew_re_s4, mnew_im_s4;
	// output register
	logic                       out_valid_q;
	cov_t                       cov_re_q, cov_im_q;
	logic                       err_q;

	logic ready_o, go4, ready4, go3, ready3, hz, go2, ready2, go1, ready1, accept;

	logic  in_err, in_upd, in_diag;
	addr_t in_addr;

	logic signed [SAMPLE_W-1:0] opc, opd;
	logic signed [FRESH_W-1:0]  fresh_re, fresh_im;
	logic                       fwd4;
	cov_t                       rd_re, rd_im, old_re, old_im;
	logic [WGT_W-1:0]           wgt;
	logic signed [ACC_W-1:0]    acc_re, acc_im;
	cov_t                       res_re, res_im;
	scs_wr_t                    wr;

	// handshake chain, from the output back to the input
	assign ready_o  = !out_valid_q || !out_stall;
	assign go4      = v_s4 && ready_o;
	assign ready4   = !v_s4 || ready_o;
	assign go3      = v_s3 && ready4;
	assign ready3   = !v_s3 || ready4;
	// hold an item whose entry is still in the multiply stage just ahead
	assign hz       = v_s3 && upd_s3 && upd_s2 && (addr_s3 == addr_s2);
	assign go2      = v_s2 && ready3 && !hz;
	assign ready2   = !v_s2 || go2;
	assign go1      = v_s1 && ready2;
	assign ready1   = !v_s1 || ready2;
	assign in_stall = clr_q || !ready1;
	assign accept   = in_valid && !in_stall;

	assign in_err  = row_chan > col_chan;
	assign in_diag = row_chan == col_chan;
	assign in_upd  = !in_err && (32'(bin_index) < BINS) && (32'(row_chan) < CHANNELS)
		&& (32'(col_chan) < CHANNELS);
	assign in_addr = ADDR_W'(32'(bin_index) * CHANNELS * CHANNELS
		+ 32'(row_chan) * CHANNELS + 32'(col_chan));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q   <= EPS_RESET;
			alpha_q <= ALPHA_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIAG_EPS:     eps_q   <= cfg_data;
				REG_SMOOTH_ALPHA: alpha_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			first_q    <= 1'b1;
		end else begin
			if (clr_q) begin
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
				end
			end
			if (accept && frame_end) begin
				first_q <= 1'b0;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= in_addr;
			upd_s1   <= in_upd;
			diag_s1  <= in_diag;
			err_s1   <= in_err;
			first_s1 <= first_q;
			rr_s1    <= row_re;
			ri_s1    <= row_im;
			cr_s1    <= col_re;
			ci_s1    <= col_im;
		end
	end

	// on the diagonal the row value is its own partner, giving power
	assign opc = diag_s1 ? rr_s1 : cr_s1;
	assign opd = diag_s1 ? ri_s1 : ci_s1;

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			fix_q <= 1'b0;
		end else begin
			if (ready2) begin
				v_s2 <= go1;
			end
			// track writes that land after the read was issued
			if (go1) begin
				fix_q <= wr.en && (wr.addr == addr_s1);
			end else if (wr.en && (wr.addr == addr_s2)) begin
				fix_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			addr_s2  <= addr_s1;
			upd_s2   <= upd_s1;
			diag_s2  <= diag_s1;
			err_s2   <= err_s1;
			first_s2 <= first_s1;
			prc_s2   <= rr_s1 * opc;
			pid_s2   <= ri_s1 * opd;
			pic_s2   <= ri_s1 * opc;
			prd_s2   <= rr_s1 * opd;
		end
		if (wr.en && (wr.addr == (go1 ? addr_s1 : addr_s2))) begin
			fix_re_q <= wr.re;
			fix_im_q <= wr.im;
		end
	end

	scs_cov_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (go1),
		.rd_addr (addr_s1),
		.rd_re   (rd_re),
		.rd_im   (rd_im)
	);

	assign fresh_re = FRESH_W'(prc_s2) + FRESH_W'(pid_s2)
		+ (diag_s2 ? signed'(FRESH_W'(eps_q)) : FRESH_W'(0));
	assign fresh_im = diag_s2 ? FRESH_W'(0) : FRESH_W'(pic_s2) - FRESH_W'(prd_s2);

	// the item in the last stage writes the same entry: take its result
	assign fwd4   = v_s4 && upd_s4 && (addr_s4 == addr_s2);
	assign old_re = fwd4 ? res_re : (fix_q ? fix_re_q : rd_re);
	assign old_im = fwd4 ? res_im : (fix_q ? fix_im_q : rd_im);

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready3) begin
			v_s3 <= go2;
		end
	end

	always_ff @(posedge clk) begin
		if (go2) begin
			addr_s3     <= addr_s2;
			upd_s3      <= upd_s2;
			diag_s3     <= diag_s2;
			err_s3      <= err_s2;
			first_s3    <= first_s2;
			fresh_re_s3 <= fresh_re;
			fresh_im_s3 <= fresh_im;
			old_re_s3   <= old_re;
			old_im_s3   <= old_im;
		end
	end

	assign wgt = ONE_Q16 - WGT_W'(alpha_q);

	// stage 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ready4) begin
			v_s4 <= go3;
		end
	end

	always_ff @(posedge clk) begin
		if (go3) begin
			addr_s4     <= addr_s3;
			upd_s4      <= upd_s3;
			diag_s4     <= diag_s3;
			err_s4      <= err_s3;
			first_s4    <= first_s3;
			fresh_re_s4 <= fresh_re_s3;
			fresh_im_s4 <= fresh_im_s3;
			mold_re_s4  <= signed'({1'b0, alpha_q}) * old_re_s3;
			mold_im_s4  <= signed'({1'b0, alpha_q}) * old_im_s3;
			mnew_re_s4  <= signed'({1'b0, wgt}) * fresh_re_s3;
			mnew_im_s4  <= signed'({1'b0, wgt}) * fresh_im_s3;
		end
	end

	assign acc_re = (ACC_W'(mold_re_s4) + ACC_W'(mnew_re_s4) + ROUND_HALF) >>> FRAC_W;
	assign acc_im = (ACC_W'(mold_im_s4) + ACC_W'(mnew_im_s4) + ROUND_HALF) >>> FRAC_W;

	always_comb begin
		res_re = '0;
		res_im = '0;
		if (upd_s4) begin
			res_re = first_s4 ? sat_cov(ACC_W'(fresh_re_s4)) : sat_cov(acc_re);
			if (!diag_s4) begin
				res_im = first_s4 ? sat_cov(ACC_W'(fresh_im_s4)) : sat_cov(acc_im);
			end
		end
	end

	always_comb begin
		wr.en   = clr_q || (go4 && upd_s4);
		wr.addr = clr_q ? clr_addr_q : addr_s4;
		wr.re   = clr_q ? '0 : res_re;
		wr.im   = clr_q ? '0 : res_im;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_o) begin
			out_valid_q <= go4;
		end
	end

	always_ff @(posedge clk) begin
		if (go4) begin
			cov_re_q <= res_re;
			cov_im_q <= res_im;
			err_q    <= err_s4;
		end
	end

	assign out_valid  = out_valid_q;
	assign cov_re     = cov_re_q;
	assign cov_im     = cov_im_q;
	assign pair_error = err_q;

endmodule

@@ sv/scs_cov_mem.sv @@
`timescale 1ns / 1ps

module scs_cov_mem
	import scs_pkg::*;
(
	input  logic    clk,
	input  scs_wr_t wr,
	input  logic    rd_en,
	input  addr_t   rd_addr,
	output cov_t    rd_re,
	output cov_t    rd_im
);

	cov_t re_mem [DEPTH];
	cov_t im_mem [DEPTH];
	cov_t rd_re_q;
	cov_t rd_im_q;

	// read returns the contents before a write at the same edge
	always_ff @(posedge clk) begin
		if (wr.en) begin
			re_mem[wr.addr] <= wr.re;
			im_mem[wr.addr] <= wr.im;
		end
		if (rd_en) begin
			rd_re_q <= re_mem[rd_addr];
			rd_im_q <= im_mem[rd_addr];
		end
	end

	assign rd_re = rd_re_q;
	assign rd_im = rd_im_q;

endmodule

@@ tb/cov_update_checker.sv @@
`timescale 1ns / 1ps

module cov_update_checker
	import scs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [BIN_W-1:0]           bin_index,
	input  logic [CHAN_W-1:0]          row_chan,
	input  logic [CHAN_W-1:0]          col_chan,
	input  logic signed [SAMPLE_W-1:0] row_re,
	input  logic signed [SAMPLE_W-1:0] row_im,
	input  logic signed [SAMPLE_W-1:0] col_re,
	input  logic signed [SAMPLE_W-1:0] col_im,
	input  logic                       frame_end,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [COV_W-1:0]    cov_re,
	input  logic signed [COV_W-1:0]    cov_im,
	input  logic                       pair_error,
	output int                         fail_count,
	output int                         results_due
);

	localparam longint COV_MAX = 64'sd2147483647;
	localparam longint COV_MIN = -64'sd2147483648;

	typedef struct {
		cov_t re;
		cov_t im;
		logic err;
	} cov_result_t;

	cov_t              real_part [DEPTH];
	cov_t              imag_part [DEPTH];
	logic              first_frame;
	logic [CFG_W-1:0]  eps;
	logic [CFG_W-1:0]  alpha;
	cov_result_t       cov_due [$];
	int                mismatches;

	function automatic cov_t clip(input longint v);
		if (v > COV_MAX) begin
			return cov_t'(COV_MAX);
		end else if (v < COV_MIN) begin
			return cov_t'(COV_MIN);
		end
		return cov_t'(v);
	endfunction

	// Take the new term as is in the first frame, else blend with alpha in Q0.16.
	function automatic cov_t blend(input cov_t old, input longint fresh);
		longint a;
		longint acc;
		if (first_frame) begin
			return clip(fresh);
		end
		a = longint'(alpha);
		acc = a * longint'(old) + (64'sd65536 - a) * fresh + 64'sd32768;
		return clip(acc >>> 16);
	endfunction

	function automatic cov_result_t update_entry();
		cov_result_t res;
		int          addr;
		longint      rr;
		longint      ri;
		longint      cr;
		longint      ci;
		res.re = '0;
		res.im = '0;
		res.err = 1'b0;
		rr = longint'(row_re);
		ri = longint'(row_im);
		cr = longint'(col_re);
		ci = longint'(col_im);
		if (row_chan > col_chan) begin
			res.err = 1'b1;
		end else if (int'(bin_index) < BINS && int'(row_chan) < CHANNELS
				&& int'(col_chan) < CHANNELS) begin
			addr = int'(bin_index) * CHANNELS * CHANNELS
				+ int'(row_chan) * CHANNELS + int'(col_chan);
			if (row_chan == col_chan) begin
				// diagonal: power plus loading, imaginary part never stored
				res.re = blend(real_part[addr], rr * rr + ri * ri + longint'(eps));
				real_part[addr] = res.re;
			end else begin
				res.re = blend(real_part[addr], rr * cr + ri * ci);
				res.im = blend(imag_part[addr], ri * cr - rr * ci);
				real_part[addr] = res.re;
				imag_part[addr] = res.im;
			end
		end
		// frame end takes effect even for a rejected item
		if (frame_end) begin
			first_frame = 1'b0;
		end
		return res;
	endfunction

	task automatic check_result();
		cov_result_t want;
		if (cov_due.size() == 0) begin
			$display("%0t: expected no result, actual cov_re %0d cov_im %0d pair_error %0b",
				$time, cov_re, cov_im, pair_error);
			mismatches++;
			return;
		end
		want = cov_due.pop_front();
		if (cov_re !== want.re) begin
			$display("%0t: cov_re expected %0d actual %0d", $time, want.re, cov_re);
			mismatches++;
		end
		if (cov_im !== want.im) begin
			$display("%0t: cov_im expected %0d actual %0d", $time, want.im, cov_im);
			mismatches++;
		end
		if (pair_error !== want.err) begin
			$display("%0t: pair_error expected %0b actual %0b",
				$time, want.err, pair_error);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				real_part[i] = '0;
				imag_part[i] = '0;
			end
			first_frame = 1'b1;
			eps = EPS_RESET;
			alpha = ALPHA_RESET;
			cov_due.delete();
			mismatches = 0;
			fail_count <= 0;
			results_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			if (in_valid && !in_stall) begin
				cov_due.push_back(update_entry());
			end
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_DIAG_EPS: begin
						eps = cfg_data;
					end
					REG_SMOOTH_ALPHA: begin
						alpha = cfg_data;
					end
				endcase
			end
			fail_count <= mismatches;
			results_due <= cov_due.size();
		end
	end

endmodule

@@ tb/spatial_covariance_smoother_test.sv @@
`timescale 1ns / 1ps

module spatial_covariance_smoother_test;
	import scs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 310;

	typedef struct {
		logic [BIN_W-1:0]           bin;
		logic [CHAN_W-1:0]          row;
		logic [CHAN_W-1:0]          col;
		logic signed [SAMPLE_W-1:0] rr;
		logic signed [SAMPLE_W-1:0] ri;
		logic signed [SAMPLE_W-1:0] cr;
		logic signed [SAMPLE_W-1:0] ci;
		logic                       fe;
	} pair_item_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_DIAG_EPS;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [BIN_W-1:0]           bin_index = '0;
	logic [CHAN_W-1:0]          row_chan = '0;
	logic [CHAN_W-1:0]          col_chan = '0;
	logic signed [SAMPLE_W-1:0] row_re = '0;
	logic signed [SAMPLE_W-1:0] row_im = '0;
	logic signed [SAMPLE_W-1:0] col_re = '0;
	logic signed [SAMPLE_W-1:0] col_im = '0;
	logic                       frame_end = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [COV_W-1:0]    cov_re;
	logic signed [COV_W-1:0]    cov_im;
	logic                       pair_error;
	int                         fail_count;
	int                         results_due;

	bit                         calm = 1'b0;
	int                         cycle_count = 0;
	pair_item_t                 last_item;

	spatial_covariance_smoother dut (.*);

	cov_update_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 13);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic pair_item_t entry_item(input int b, input int r, input int c,
			input int rr, input int ri, input int cr, input int ci, input bit fe);
		pair_item_t it;
		it.bin = BIN_W'(b);
		it.row = CHAN_W'(r);
		it.col = CHAN_W'(c);
		it.rr = SAMPLE_W'(rr);
		it.ri = SAMPLE_W'(ri);
		it.cr = SAMPLE_W'(cr);
		it.ci = SAMPLE_W'(ci);
		it.fe = fe;
		return it;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int p;
		p = $urandom_range(99);
		if (p < 12) begin
			case ($urandom_range(3))
				0: return SAMPLE_W'(-32768);
				1: return SAMPLE_W'(32767);
				2: return SAMPLE_W'(0);
				default: return SAMPLE_W'(-1);
			endcase
		end else if (p < 25) begin
			return SAMPLE_W'($urandom_range(64) - 32);
		end
		return SAMPLE_W'($urandom_range(65535));
	endfunction

	// Mostly valid pairs over a few bins; a quarter reuse the previous entry.
	function automatic pair_item_t random_item();
		pair_item_t it;
		int         p;
		it = last_item;
		if ($urandom_range(99) >= 25) begin
			p = $urandom_range(99);
			if (p < 55) begin
				it.bin = BIN_W'($urandom_range(7));
			end else if (p < 85) begin
				it.bin = BIN_W'($urandom_range(256));
			end else begin
				it.bin = BIN_W'($urandom_range(511));
			end
			if ($urandom_range(99) < 8) begin
				it.col = CHAN_W'($urandom_range(2));
				it.row = CHAN_W'($urandom_range(3, it.col + 1));
			end else begin
				it.row = CHAN_W'($urandom_range(3));
				it.col = CHAN_W'($urandom_range(3, it.row));
			end
		end
		it.rr = rand_sample();
		it.ri = rand_sample();
		it.cr = rand_sample();
		it.ci = rand_sample();
		it.fe = ($urandom_range(19) == 0);
		return it;
	endfunction

	task automatic offer(input pair_item_t it);
		if (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		bin_index <= it.bin;
		row_chan <= it.row;
		col_chan <= it.col;
		row_re <= it.rr;
		row_im <= it.ri;
		col_re <= it.cr;
		col_im <= it.ci;
		frame_end <= it.fe;
		do @(posedge clk); while (in_stall);
		last_item = it;
	endtask

	// Hold the input until every outstanding result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	task automatic load_weights(input logic [CFG_W-1:0] eps_val,
			input logic [CFG_W-1:0] alpha_val);
		cfg_write <= 1'b1;
		cfg_index <= REG_DIAG_EPS;
		cfg_data <= eps_val;
		@(posedge clk);
		cfg_index <= REG_SMOOTH_ALPHA;
		cfg_data <= alpha_val;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// first frame with reset weights, then rejected items, the last one ending the frame
		offer(entry_item(0, 0, 0, -32768, -32768, 32767, 32767, 1'b0));
		offer(entry_item(0, 0, 1, 32767, -32768, -32768, 32767, 1'b0));
		offer(entry_item(256, 3, 3, 32767, 32767, 0, 0, 1'b0));
		offer(entry_item(256, 0, 3, -32768, -32768, -32768, -32768, 1'b0));
		offer(entry_item(257, 1, 2, 1000, -1000, 2000, -2000, 1'b0));
		offer(entry_item(511, 0, 0, 32767, 32767, 32767, 32767, 1'b0));
		offer(entry_item(5, 3, 0, 100, 200, 300, 400, 1'b0));
		offer(entry_item(511, 2, 1, -1, -1, -1, -1, 1'b1));
		// second frame: smoothing, including back-to-back hits on one entry
		offer(entry_item(0, 0, 0, 0, 0, 0, 0, 1'b0));
		offer(entry_item(0, 0, 1, 1, -1, -1, 1, 1'b0));
		offer(entry_item(256, 0, 3, -32768, -32768, -32768, -32768, 1'b0));
		offer(entry_item(256, 3, 3, 0, 0, 0, 0, 1'b0));
		offer(entry_item(0, 0, 1, 32767, 32767, -32768, 32767, 1'b0));
		offer(entry_item(0, 0, 1, -32768, 0, 32767, -32768, 1'b0));
		settle();
		load_weights(16'hFFFF, 16'h0000);
		offer(entry_item(0, 0, 0, -32768, -32768, 0, 0, 1'b0));
		offer(entry_item(1, 2, 3, 32767, -32768, 32767, -32768, 1'b0));
		offer(entry_item(1, 2, 3, -32768, 32767, -32768, 32767, 1'b0));
		settle();
		load_weights(16'h0000, 16'hFFFF);
		offer(entry_item(0, 0, 0, 0, 0, 0, 0, 1'b0));
		offer(entry_item(256, 0, 3, 32767, 32767, 32767, 32767, 1'b0));
		offer(entry_item(2, 1, 1, -1, -1, 5, 5, 1'b0));

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: load_weights(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)));
				1: load_weights(16'h0000, 16'hFFFF);
				2: load_weights(16'hFFFF, 16'h0000);
				3: load_weights(CFG_W'($urandom_range(65535)), 16'h8000);
				4: load_weights(CFG_W'($urandom_range(65535)),
					CFG_W'($urandom_range(65535, 60000)));
				default: load_weights(CFG_W'($urandom_range(65535)),
					CFG_W'($urandom_range(65535)));
			endcase
			calm <= (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == PHASE_ITEMS / 2) begin
					settle();
				end
				offer(random_item());
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && results_due == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/scs_pkg.sv
sv/scs_cov_mem.sv
sv/spatial_covariance_smoother.sv
tb/cov_update_checker.sv
tb/spatial_covariance_smoother_test.sv
